/* rtl/ssc_pkg.sv */
// shared types and constants for the stock span calculator
`default_nettype none

package ssc_pkg;

    // fixed field widths of the item ports
    localparam int HEIGHT_W = 16;
    localparam int SPAN_W   = 11;

    // move command broadcast down the stack chain
    typedef struct packed {
        logic push;
        logic pop;
    } ssc_shift_t;

endpackage

`default_nettype wire

/* rtl/ssc_cell.sv */
// one stack cell: holds a height and its position, shifts with its neighbors
`default_nettype none

module ssc_cell #(
    parameter int HEIGHT_BITS = 16,
    parameter int POS_W       = 10
) (
    input  wire                      clk,
    input  ssc_pkg::ssc_shift_t      shift,
    input  wire  [HEIGHT_BITS-1:0]   above_height,
    input  wire  [POS_W-1:0]         above_pos,
    input  wire  [HEIGHT_BITS-1:0]   below_height,
    input  wire  [POS_W-1:0]         below_pos,
    output logic [HEIGHT_BITS-1:0]   cell_height,
    output logic [POS_W-1:0]         cell_pos
);
    import ssc_pkg::*;

    logic [HEIGHT_BITS-1:0] height_reg;
    logic [HEIGHT_BITS-1:0] height_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;

    // push takes the entry above, pop takes the entry below
    always_comb
    begin
        height_next = height_reg;
        pos_next    = pos_reg;
        priority if (shift.push)
        begin
            height_next = above_height;
            pos_next    = above_pos;
        end
        else if (shift.pop)
        begin
            height_next = below_height;
            pos_next    = below_pos;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        pos_reg    <= pos_next;
    end

    assign cell_height = height_reg;
    assign cell_pos    = pos_reg;

endmodule

`default_nettype wire

/* rtl/stock_span_calculator_core.sv */
// top level of the stock span calculator: control and the stack cell chain
`default_nettype none

// Stock span calculator. Each input beat carries one height; each output beat
// carries its span (this height plus the unbroken run of earlier heights of the
// same sequence that are not greater) and an overflow flag. start_req opens a
// new sequence; after reset a sequence is already open. The monotonic stack is
// a chain of STACK_DEPTH cells with its top in cell 0, so only cell 0 is ever
// compared. An item is handled in steps: the beat is taken, then each entry it
// pops is popped (the chain moves one place per cycle), then the push and the
// result load happen together, once the output register is free or being read.
// Pops are bounded by earlier pushes. The result sits in an output register, so
// the next beat is taken while it waits. Once a sequence holds STACK_DEPTH items,
// further items get span STACK_DEPTH (low 11 bits) with overflow set, and the
// stack holds until the next start_req.
module stock_span_calculator_core #(
    parameter int STACK_DEPTH = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           start_req,
    input  wire  [ssc_pkg::HEIGHT_W-1:0]  height,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [ssc_pkg::SPAN_W-1:0]    span,
    output logic                          overflow
);
    import ssc_pkg::*;

    localparam int POS_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       pos_next;
    logic [HEIGHT_BITS-1:0] h_reg;
    logic [HEIGHT_BITS-1:0] h_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SPAN_W-1:0]      span_reg;
    logic [SPAN_W-1:0]      span_next;
    logic                   overflow_reg;
    logic                   overflow_next;

    logic [HEIGHT_BITS+HEIGHT_W-1:0] height_wide;
    logic [SPAN_W+CNT_W-1:0]         span_wide;
    logic [SPAN_W+CNT_W-1:0]         sat_wide;
    logic [CNT_W-1:0]                span_cnt;
    logic                            in_beat;
    logic                            is_full;
    logic                            top_le;
    logic                            pop_now;
    logic                            finish;
    logic                            push_now;
    ssc_shift_t                      shift;

    logic [HEIGHT_BITS-1:0] cell_height [STACK_DEPTH];
    logic [POS_W-1:0]       cell_pos    [STACK_DEPTH];

    // bring the height port to the stored width
    assign height_wide = {{HEIGHT_BITS{1'b0}}, height};
    assign in_beat     = in_valid && in_ready;
    assign in_ready    = (state_reg == ST_IDLE);

    // pop decision looks at the top cell only
    assign is_full  = (pos_reg >= CNT_W'(STACK_DEPTH));
    assign top_le   = (count_reg != '0) && (cell_height[0] <= h_reg);
    assign pop_now  = (state_reg == ST_WORK) && !is_full && top_le;
    assign finish   = (state_reg == ST_WORK) && !pop_now && (!out_valid_reg || out_ready);
    assign push_now = finish && !is_full && (count_reg < CNT_W'(STACK_DEPTH));

    assign shift.push = push_now;
    assign shift.pop  = pop_now;

    // span from the top entry's position, or from the sequence start
    assign span_cnt  = (count_reg == '0) ? (pos_reg + CNT_W'(1))
                                         : (pos_reg - CNT_W'(cell_pos[0]));
    assign span_wide = {{SPAN_W{1'b0}}, span_cnt};
    assign sat_wide  = {{SPAN_W{1'b0}}, CNT_W'(STACK_DEPTH)};

    // control and result next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        h_next         = h_reg;
        out_valid_next = out_valid_reg;
        span_next      = span_reg;
        overflow_next  = overflow_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    h_next     = height_wide[HEIGHT_BITS-1:0];
                    state_next = ST_WORK;
                    if (start_req)
                    begin
                        count_next = '0;
                        pos_next   = '0;
                    end
                end
            end
            ST_WORK:
            begin
                if (pop_now)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else if (finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (is_full)
                    begin
                        span_next     = sat_wide[SPAN_W-1:0];
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        span_next     = span_wide[SPAN_W-1:0];
                        overflow_next = 1'b0;
                        pos_next      = pos_reg + CNT_W'(1);
                        if (push_now)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        span_reg     <= span_next;
        overflow_reg <= overflow_next;
    end

    // stack chain, top of stack in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [HEIGHT_BITS-1:0] up_height;
            logic [POS_W-1:0]       up_pos;
            logic [HEIGHT_BITS-1:0] dn_height;
            logic [POS_W-1:0]       dn_pos;

            if (gi == 0)
            begin : g_top
                assign up_height = h_reg;
                assign up_pos    = pos_reg[POS_W-1:0];
            end
            else
            begin : g_mid
                assign up_height = cell_height[gi-1];
                assign up_pos    = cell_pos[gi-1];
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_bot
                assign dn_height = '0;
                assign dn_pos    = '0;
            end
            else
            begin : g_low
                assign dn_height = cell_height[gi+1];
                assign dn_pos    = cell_pos[gi+1];
            end

            ssc_cell #(
                .HEIGHT_BITS (HEIGHT_BITS),
                .POS_W       (POS_W)
            ) u_cell (
                .clk          (clk),
                .shift        (shift),
                .above_height (up_height),
                .above_pos    (up_pos),
                .below_height (dn_height),
                .below_pos    (dn_pos),
                .cell_height  (cell_height[gi]),
                .cell_pos     (cell_pos[gi])
            );
        end
    endgenerate

    assign out_valid = out_valid_reg;
    assign span      = span_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

/* rtl/ssc_checker.sv */
// port-level checks for the stock span calculator, bound to the top level
`default_nettype none

module ssc_checker #(
    parameter int STACK_DEPTH = 1024
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [ssc_pkg::SPAN_W-1:0]    span,
    input wire                          overflow
);
    import ssc_pkg::*;

    localparam logic [31:0]       DEPTH_32 = 32'(STACK_DEPTH);
    localparam logic [SPAN_W-1:0] SAT_SPAN = DEPTH_32[SPAN_W-1:0];

    // one height beat at a time: input closes after a beat is taken
    a_in_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second height beat taken while one is in work");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(span) && $stable(overflow))
        else $error("result beat changed while stalled");

    // every span counts at least the item itself
    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> span != '0)
        else $error("span of zero");

    // saturated results carry the capacity
    a_sat_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> span == SAT_SPAN)
        else $error("overflow beat without saturated span");

    // a span never exceeds the capacity
    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(span) <= DEPTH_32)
        else $error("span beyond capacity");

endmodule

bind stock_span_calculator_core ssc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_ssc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .span      (span),
    .overflow  (overflow)
);

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the stock span calculator core
`timescale 1ns / 1ps

module tb_top;

    import ssc_pkg::*;

    localparam int STACK_DEPTH  = 1024;
    localparam int HEIGHT_BITS  = 16;
    localparam int ITEM_TARGET  = 1150;
    localparam int LONG_SEQ_LEN = STACK_DEPTH + 6;
    localparam int IDLE_LIMIT   = 20000;
    localparam int MAX_REPORTS  = 10;

    // one expected output beat
    typedef struct {
        logic [SPAN_W-1:0] span;
        logic              overflow;
    } span_beat_t;

    // span predictor over its own monotonic stack, plus the queue of spans due
    class span_scoreboard;
        logic [HEIGHT_W-1:0] tower_heights [STACK_DEPTH];
        int unsigned         tower_positions [STACK_DEPTH];
        int unsigned         tower_count;
        int unsigned         seq_position;
        span_beat_t          spans_due [$];
        int                  mismatches;

        // predict the span of an accepted height and queue it
        function void note_height(logic first, logic [HEIGHT_W-1:0] h);
            span_beat_t  due;
            int unsigned run;
            if (first)
            begin
                tower_count  = 0;
                seq_position = 0;
            end
            if (seq_position >= STACK_DEPTH)
            begin
                // capacity exceeded: saturate, leave the stack alone
                due.span     = SPAN_W'(STACK_DEPTH);
                due.overflow = 1'b1;
            end
            else
            begin
                // pop every earlier height not greater than this one
                while (tower_count > 0 && tower_heights[tower_count-1] <= h)
                    tower_count--;
                if (tower_count == 0)
                    run = seq_position + 1;
                else
                    run = seq_position - tower_positions[tower_count-1];
                if (tower_count < STACK_DEPTH)
                begin
                    tower_heights[tower_count]   = h;
                    tower_positions[tower_count] = seq_position;
                    tower_count++;
                end
                seq_position++;
                due.span     = SPAN_W'(run);
                due.overflow = 1'b0;
            end
            spans_due.push_back(due);
        endfunction

        // compare an output beat with the oldest span due
        function void check_span(logic [SPAN_W-1:0] got_span, logic got_overflow);
            span_beat_t due;
            if (spans_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("error: output beat with none due: span %0d overflow %0b",
                             got_span, got_overflow);
                return;
            end
            due = spans_due.pop_front();
            if (got_span !== due.span || got_overflow !== due.overflow)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("error: span %0d overflow %0b, expected span %0d overflow %0b",
                             got_span, got_overflow, due.span, due.overflow);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                start_req;
    logic [HEIGHT_W-1:0] height;
    logic                out_valid;
    logic                out_ready;
    logic [SPAN_W-1:0]   span;
    logic                overflow;

    span_scoreboard board;
    int             items_sent;
    int             calm_left;
    int             idle_cycles;

    stock_span_calculator_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_req (start_req),
        .height    (height),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .span      (span),
        .overflow  (overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // reset, asserted at start and then released
    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // beat monitor: both channels sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_height(start_req, height);
            if (out_valid && out_ready)
                board.check_span(span, overflow);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side: ready runs broken by stalls, sometimes a long calm run
    initial
    begin
        int run;
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                run = 300;
            else
                run = $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // send one height beat, after an optional gap
    task automatic send_height(input logic first, input logic [HEIGHT_W-1:0] h);
        int gap;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0)
                calm_left = 60;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= first;
        height    <= h;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // height for position idx of a sequence in a given shape
    function automatic logic [HEIGHT_W-1:0] shaped_height(int shape, int idx);
        case (shape)
            0:       return HEIGHT_W'($urandom);
            1:       return HEIGHT_W'($urandom_range(0, 7));
            2:       return HEIGHT_W'(idx * 37 + $urandom_range(0, 40));
            3:       return HEIGHT_W'(60000 - idx * 53 - $urandom_range(0, 40));
            default: return HEIGHT_W'((idx % 6) * 10000 + $urandom_range(0, 3));
        endcase
    endfunction

    // stimulus
    initial
    begin
        int shape;
        int seq_len;
        bit long_done;
        board       = new;
        items_sent  = 0;
        calm_left   = 0;
        long_done   = 1'b0;
        in_valid  <= 1'b0;
        start_req <= 1'b0;
        height    <= '0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // sequence open after reset, equal heights, extremes
        send_height(1'b0, 16'd100);
        send_height(1'b0, 16'd50);
        send_height(1'b0, 16'd50);
        send_height(1'b0, 16'd0);
        send_height(1'b0, 16'hFFFF);
        send_height(1'b1, 16'hFFFF);
        send_height(1'b0, 16'hFFFF);
        send_height(1'b0, 16'd0);
        send_height(1'b0, 16'd0);
        send_height(1'b1, 16'd0);
        send_height(1'b0, 16'd1);
        send_height(1'b0, 16'd2);
        send_height(1'b0, 16'd3);
        // descending then one that pops part of the stack
        send_height(1'b1, 16'd40000);
        send_height(1'b0, 16'd30000);
        send_height(1'b0, 16'd20000);
        send_height(1'b0, 16'd35000);
        send_height(1'b0, 16'hAAAA);
        send_height(1'b0, 16'h5555);
        send_height(1'b1, 16'h5555);
        send_height(1'b0, 16'hAAAA);

        // random sequences, one of them long enough to overflow
        while (items_sent < ITEM_TARGET)
        begin
            if (!long_done && items_sent > 60)
            begin
                long_done = 1'b1;
                for (int i = 0; i < LONG_SEQ_LEN; i++)
                begin
                    if (i < STACK_DEPTH / 2)
                        send_height(i == 0, HEIGHT_W'(65000 - i * 100));
                    else if (i == STACK_DEPTH - 1)
                        send_height(1'b0, 16'hFFFF);
                    else
                        send_height(1'b0, shaped_height($urandom_range(0, 4), i));
                end
            end
            else
            begin
                shape = $urandom_range(0, 4);
                if ($urandom_range(0, 7) == 0)
                    seq_len = 1;
                else
                    seq_len = $urandom_range(2, 30);
                for (int i = 0; i < seq_len; i++)
                    send_height(i == 0, shaped_height(shape, i));
            end
        end
        in_valid <= 1'b0;

        // drain, then a short tail for stray beats
        while (board.spans_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* stock_span_calculator_core.f */
rtl/ssc_pkg.sv
rtl/ssc_cell.sv
rtl/stock_span_calculator_core.sv
rtl/ssc_checker.sv
tb/tb_top.sv
